/* rtl/core/sha_pkg.sv */
package sha_pkg;

	localparam int unsigned WordW = 32;

	// one queued block job for the compression unit
	typedef struct packed {
		logic [511:0] block;
		logic         first;
		logic         final_blk;
	} sha_job_t;

	// reports from the compression unit back to the top level
	typedef struct packed {
		logic         busy;
		logic         done;
		logic [255:0] digest;
	} sha_core_stat_t;

	function automatic logic [31:0] round_const(input logic [5:0] idx);
		logic [31:0] k;
		case (idx)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	localparam logic [255:0] InitHash = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [7:0] PadByte = 8'h80;

endpackage

/* rtl/core/sha_front.sv */
module sha_front import sha_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     data_byte,
	input  logic           has_byte,
	input  logic           last,
	output logic           job_valid,
	input  logic           job_ready,
	output sha_job_t       job
);

	typedef enum logic [2:0] {
		ST_BYTES = 3'b001,
		ST_PAD   = 3'b010,
		ST_LEN   = 3'b100
	} front_state_t;

	front_state_t state_q;
	logic [511:0] buf_q;
	logic [63:0]  total_q;
	logic         first_q;
	logic         job_valid_q;
	sha_job_t     job_q;

	logic [5:0]   fill;
	logic [511:0] buf_ins;
	logic [63:0]  total_nx;
	logic         slot_free;

	assign fill      = total_q[5:0];
	assign slot_free = !job_valid_q || job_ready;
	assign in_ready  = (state_q == ST_BYTES) && slot_free;
	assign job_valid = job_valid_q;
	assign job       = job_q;

	// byte goes to the big-endian slot for the current fill
	always_comb begin
		buf_ins = buf_q;
		buf_ins[511 - 8*fill -: 8] = data_byte;
		total_nx = total_q + 64'd1;
	end

	// byte gathering, block emission and padding sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_BYTES;
			total_q     <= '0;
			first_q     <= 1'b1;
			job_valid_q <= 1'b0;
		end else begin
			if (job_ready) job_valid_q <= 1'b0;
			case (state_q)
				ST_BYTES: begin
					if (in_valid && in_ready) begin
						if (has_byte) begin
							buf_q   <= buf_ins;
							total_q <= total_nx;
							if (total_nx[5:0] == 6'd0) begin
								job_q       <= '{block: buf_ins, first: first_q, final_blk: 1'b0};
								job_valid_q <= 1'b1;
								first_q     <= 1'b0;
							end
						end
						if (last) state_q <= ST_PAD;
					end
				end
				ST_PAD: begin
					if (slot_free) begin
						if (fill > 6'd55) begin
							job_q.first     <= first_q;
							job_q.final_blk <= 1'b0;
							job_valid_q     <= 1'b1;
							first_q         <= 1'b0;
							for (int i = 0; i < 64; i++) begin
								if (6'(i) == fill) job_q.block[511 - 8*i -: 8] <= PadByte;
								else if (6'(i) > fill) job_q.block[511 - 8*i -: 8] <= 8'h00;
								else job_q.block[511 - 8*i -: 8] <= buf_q[511 - 8*i -: 8];
							end
							buf_q <= '0;
						end else begin
							// mark byte then zeros after it
							for (int i = 0; i < 64; i++) begin
								if (6'(i) == fill) buf_q[511 - 8*i -: 8] <= PadByte;
								else if (6'(i) > fill) buf_q[511 - 8*i -: 8] <= 8'h00;
							end
						end
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					if (slot_free) begin
						job_q       <= '{block: {buf_q[511:64], total_q[60:0], 3'b000},
							first: first_q, final_blk: 1'b1};
						job_valid_q <= 1'b1;
						first_q     <= 1'b1;
						total_q     <= '0;
						state_q     <= ST_BYTES;
					end
				end
				default: state_q <= ST_BYTES;
			endcase
		end
	end

	// a pending job holds until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && !job_ready |=> job_valid && $stable(job))
		else $error("queued job changed while stalled");
	// bytes only taken while gathering
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_BYTES)
		else $error("input ready outside gathering");
	// a final block resets the chaining flag
	assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_q && job_ready && job_q.final_blk && !(in_valid && in_ready && has_byte)
		|=> first_q || job_valid_q)
		else $error("final block lost chaining restart");

endmodule

/* rtl/core/sha_queue.sv */
module sha_queue import sha_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_valid,
	output logic     wr_ready,
	input  sha_job_t wr_job,
	output logic     rd_valid,
	input  logic     rd_ready,
	output sha_job_t rd_job
);

	sha_job_t mem_q [2];
	logic     wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic     push, pop;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_job   = mem_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// two-entry job storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wr_job;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop) rptr_q <= !rptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("queue count slip");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> (wptr_q == rptr_q))
		else $error("queue pointers out of step");

endmodule

/* rtl/core/sha_compress.sv */
module sha_compress import sha_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_ready,
	input  sha_job_t       job,
	input  logic           res_free,
	output sha_core_stat_t stat
);

	logic         busy_q, final_q, fold_q;
	logic [5:0]   rnd_q;
	logic [255:0] hash_q;
	logic [31:0]  a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [31:0]  w_q [16];

	logic [31:0] s0, s1, ch, maj, t1, t2, wt, wnew, w1, w14;
	logic [255:0] hash_sum, base;

	// a final job waits until the result register is free
	assign job_ready = !busy_q && !fold_q && !(job.final_blk && !res_free);
	assign w1  = w_q[1];
	assign w14 = w_q[14];
	assign wt  = w_q[0];

	// schedule word and round function
	always_comb begin
		s0   = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
		s1   = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
		wnew = s1 + w_q[9] + s0 + w_q[0];
		ch   = (e_q & f_q) ^ (~e_q & g_q);
		maj  = (a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q);
		t1   = h_q + ({e_q[5:0], e_q[31:6]} ^ {e_q[10:0], e_q[31:11]} ^ {e_q[24:0], e_q[31:25]})
			+ ch + round_const(rnd_q) + wt;
		t2   = ({a_q[1:0], a_q[31:2]} ^ {a_q[12:0], a_q[31:13]} ^ {a_q[21:0], a_q[31:22]}) + maj;
		hash_sum = {hash_q[255:224] + a_q, hash_q[223:192] + b_q, hash_q[191:160] + c_q,
			hash_q[159:128] + d_q, hash_q[127:96] + e_q, hash_q[95:64] + f_q,
			hash_q[63:32] + g_q, hash_q[31:0] + h_q};
		base = job.first ? InitHash : hash_q;
	end

	// one round per cycle over a sliding sixteen-word window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= '0;
			hash_q <= InitHash;
		end else begin
			if (job_valid && job_ready) begin
				busy_q  <= 1'b1;
				final_q <= job.final_blk;
				rnd_q   <= '0;
				hash_q  <= base;
				{a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q} <= base;
				for (int i = 0; i < 16; i++) w_q[i] <= job.block[511 - 32*i -: 32];
			end else if (busy_q) begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
				w_q[15] <= wnew;
				h_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
				d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) busy_q <= 1'b0;
			end
			// fold working variables into chain after the last round
			if (fold_q) hash_q <= hash_sum;
		end
	end

	// finish step: registered in the cycle after the last round
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_q <= 1'b0;
		end else begin
			fold_q <= busy_q && rnd_q == 6'd63;
		end
	end

	always_comb begin
		stat.busy   = busy_q || fold_q;
		stat.done   = fold_q && final_q;
		stat.digest = hash_sum;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && rnd_q == 6'd63 |=> !busy_q && fold_q)
		else $error("round count slip");
	assert property (@(posedge clk) disable iff (!arst_n) fold_q |-> !job_ready)
		else $error("fold overlap");
	assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && job_ready |=> busy_q && rnd_q == 6'd0)
		else $error("job start missed");

endmodule

/* rtl/core/sha256_hash_engine.sv */
// SHA-256 streaming hash engine
// s_axis carries one message item per transfer: a byte, a flag saying the byte
// is present, and tlast ending the message. An item with neither flag does
// nothing; an item with only tlast hashes what came before (or the empty one).
// m_axis carries one 256-bit digest per message, digest_high in the low 64 bits,
// each 64-bit field big-endian.
// Throughput: bytes are taken one per cycle into the block buffer while the
// front end gathers and its job slot is free; each full 64-byte block goes
// through a two-entry queue to the round unit, which loads it, runs 64 rounds
// and folds; the round unit sets the sustained rate, and bytes can keep arriving
// while it works. After tlast the front end steps through its pad and length
// states, then one or two blocks pass the round unit, then the digest register.
// Reset clears the buffer state, the queue and the output valid; the chain
// starts from the standard initial values.
// If m_axis stalls, the held digest blocks only the next final block; bytes
// and earlier blocks of the next message keep flowing.
module sha256_hash_engine import sha_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,  // data_byte
	input  logic         s_axis_tuser,  // has_byte
	input  logic         s_axis_tlast,  // last
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// digest_high, digest_upper_mid, digest_lower_mid, digest_low
	output logic [255:0] m_axis_tdata
);

	sha_job_t       fq_job, qc_job;
	logic           fq_valid, fq_ready, qc_valid, qc_ready;
	sha_core_stat_t stat;
	logic           out_valid_q;
	logic [255:0]   out_data_q;

	sha_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.data_byte(s_axis_tdata), .has_byte(s_axis_tuser), .last(s_axis_tlast),
		.job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
	);

	sha_queue u_queue (
		.clk, .arst_n,
		.wr_valid(fq_valid), .wr_ready(fq_ready), .wr_job(fq_job),
		.rd_valid(qc_valid), .rd_ready(qc_ready), .rd_job(qc_job)
	);

	sha_compress u_comp (
		.clk, .arst_n,
		.job_valid(qc_valid), .job_ready(qc_ready), .job(qc_job),
		.res_free(!out_valid_q), .stat
	);

	// digest output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (m_axis_tready) out_valid_q <= 1'b0;
			if (stat.done) out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) out_data_q <= stat.digest;
	end

	// digest word order: first chain word lands in the lowest field, big-endian
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_data_q[63:0], out_data_q[127:64],
		out_data_q[191:128], out_data_q[255:192]};

	assert property (@(posedge clk) disable iff (!arst_n) stat.done |-> !out_valid_q)
		else $error("digest overwritten");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("digest dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("digest changed while stalled");

endmodule

/* tb/sha256_checker.sv */
`timescale 1ns / 100ps

module sha256_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,
	input  logic         s_axis_tuser,
	input  logic         s_axis_tlast,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [255:0] m_axis_tdata,
	output int           fail_count,
	output int           digests_pending
);

	typedef struct {
		logic [63:0] high;
		logic [63:0] upper_mid;
		logic [63:0] lower_mid;
		logic [63:0] low;
	} digest_t;

	localparam logic [31:0] KTab [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	logic [31:0] chain [8];
	logic [63:0] byte_total;
	logic [7:0]  block_buf [64];
	digest_t     digest_q [$];

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// one 64-round compression of block_buf into chain
	task automatic compress();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2, s0, s1;
		for (int i = 0; i < 16; i++)
			w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = s1 + w[i-7] + s0 + w[i-16];
		end
		v = chain;
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTab[i] + w[i];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] += v[i];
	endtask

	task automatic start_message();
		chain = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		byte_total = '0;
	endtask

	// apply one input transfer; pad and queue a digest on tlast
	task automatic absorb_item(input logic [7:0] b, input logic has_b, input logic lst);
		logic [63:0] bits;
		int fill;
		digest_t d;
		if (has_b) begin
			block_buf[byte_total[5:0]] = b;
			byte_total++;
			if (byte_total[5:0] == 0)
				compress();
		end
		if (lst) begin
			bits = byte_total << 3;
			fill = byte_total[5:0];
			block_buf[fill++] = 8'h80;
			if (fill > 56) begin
				for (int i = fill; i < 64; i++)
					block_buf[i] = '0;
				compress();
				fill = 0;
			end
			for (int i = fill; i < 56; i++)
				block_buf[i] = '0;
			for (int i = 0; i < 8; i++)
				block_buf[56+i] = bits[63-8*i -: 8];
			compress();
			d.high      = {chain[0], chain[1]};
			d.upper_mid = {chain[2], chain[3]};
			d.lower_mid = {chain[4], chain[5]};
			d.low       = {chain[6], chain[7]};
			digest_q.push_back(d);
			start_message();
		end
	endtask

	task automatic compare_field(input string name, input logic [63:0] exp_v,
		input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, actual %h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
		start_message();
	end

	assign digests_pending = digest_q.size();

	// watch both channels at each rising edge
	always @(posedge clk) begin
		digest_t d;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				absorb_item(s_axis_tdata, s_axis_tuser, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				if (digest_q.size() == 0) begin
					$error("digest transfer with no digest expected: %h", m_axis_tdata);
					fail_count++;
				end else begin
					d = digest_q.pop_front();
					compare_field("digest_high", d.high, m_axis_tdata[63:0]);
					compare_field("digest_upper_mid", d.upper_mid, m_axis_tdata[127:64]);
					compare_field("digest_lower_mid", d.lower_mid, m_axis_tdata[191:128]);
					compare_field("digest_low", d.low, m_axis_tdata[255:192]);
				end
			end
		end
	end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata;  // data_byte
	logic         s_axis_tuser;  // has_byte
	logic         s_axis_tlast;  // last
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [255:0] m_axis_tdata;  // digest_high up to digest_low
	int           fail_count;
	int           digests_pending;

	sha256_hash_engine dut (.*);

	sha256_checker u_checker (.*);

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 90);
	endfunction

	// one input transfer after an optional gap, waiting for the handshake
	task automatic send_item(input logic [7:0] b, input logic has_b, input logic lst);
		int g;
		g = gap_len();
		if (g != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= has_b;
		s_axis_tlast  <= lst;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// a message of n bytes, with random empty items mixed in when noisy
	task automatic send_message(input int n, input bit noisy, input bit zero_end);
		for (int i = 0; i < n; i++) begin
			if (noisy && $urandom_range(0, 9) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			if (zero_end || i != n - 1)
				send_item(8'($urandom), 1'b1, 1'b0);
			else
				send_item(8'($urandom), 1'b1, 1'b1);
		end
		if (zero_end || n == 0)
			send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	// receiver stalls
	initial begin
		int g;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			g = gap_len();
			m_axis_tready <= (g == 0);
			repeat (g == 0 ? $urandom_range(1, 20) : g) @(posedge clk);
		end
	end

	initial begin
		int sent;
		int n;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		s_axis_tlast  = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty message, ignored items, data extremes, padding edges
		send_item(8'hff, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hff, 1'b0, 1'b1);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'h55, 1'b1, 1'b0);
		send_item(8'haa, 1'b0, 1'b0);
		send_item(8'haa, 1'b1, 1'b1);
		send_message(55, 1'b0, 1'b0);
		send_message(56, 1'b0, 1'b1);
		send_message(64, 1'b0, 1'b0);
		send_message(63, 1'b0, 1'b1);
		sent = 8 + 55 + 57 + 64 + 64;

		// random messages, mostly short, a few spanning several blocks
		while (sent < 1350) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 200) : $urandom_range(0, 70);
			send_message(n, 1'b1, $urandom_range(0, 1));
			sent += n + 1;
		end
		s_axis_tvalid <= 1'b0;

		// drain, then allow the round unit to settle
		while (digests_pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("sha256_hash_engine regression: pass");
		else
			$display("sha256_hash_engine regression: fail");
		$finish;
	end

	initial begin
		#20ms;
		$display("sha256_hash_engine regression: fail");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/sha_pkg.sv
rtl/core/sha_front.sv
rtl/core/sha_queue.sv
rtl/core/sha_compress.sv
rtl/core/sha256_hash_engine.sv
tb/sha256_checker.sv
tb/tb_top.sv
